### sv/lbgv_pkg.sv
// Shared constants, codes and sideband types of the Lorentz boost pipeline.
package lbgv_pkg;

  localparam int MOM_W      = 32;
  localparam int BETA_W     = 32;
  localparam int BETA_FRAC  = 30;
  localparam int GAMMA_FRAC = 32;
  localparam int BP_W       = 2 * BETA_W + 2;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FTL   = 2'd1,
    STATUS_LIGHT = 2'd2,
    STATUS_SAT   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_BOOST,
    KIND_PASS,
    KIND_FTL,
    KIND_LIGHT
  } kind_e;

  typedef struct packed {
    logic [3:0][MOM_W-1:0]  mom;
    logic [2:0][BETA_W-1:0] beta;
    logic signed [BP_W-1:0] bp;
    kind_e                  kind;
  } side_t;

endpackage

### sv/lbgv_mul.sv
// Two-stage signed multiplier built from registered 33x33 partial products.
module lbgv_mul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int WR = 64
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic signed [WR-1:0] p_o
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;

  logic signed [NA*32-1:0] a_x;
  logic signed [NB*32-1:0] b_x;
  logic signed [32:0]      a_c [NA];
  logic signed [32:0]      b_c [NB];
  logic signed [65:0]      pp_q [NA][NB];
  logic signed [WR-1:0]    sum_d;
  logic signed [WR-1:0]    p_q;

  assign a_x = (NA*32)'(a_i);
  assign b_x = (NB*32)'(b_i);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        a_c[i] = $signed({a_x[32*i+31], a_x[32*i +: 32]});
      end else begin
        a_c[i] = $signed({1'b0, a_x[32*i +: 32]});
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        b_c[j] = $signed({b_x[32*j+31], b_x[32*j +: 32]});
      end else begin
        b_c[j] = $signed({1'b0, b_x[32*j +: 32]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_c[i] * b_c[j];
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (WR'(pp_q[i][j]) <<< (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

### sv/lbgv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with payload.
module lbgv_div #(
  parameter int NW = 32,
  parameter int DW = 32,
  parameter int PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  logic          vld_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [PW-1:0] pay_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic          v_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [PW-1:0] p_in;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in = vld_i;
      assign n_in = num_i;
      assign q_in = '0;
      assign r_in = rem_i;
      assign d_in = den_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign v_in = vld_q[i-1];
      assign n_in = num_q[i-1];
      assign q_in = quo_q[i-1];
      assign r_in = rem_q[i-1];
      assign d_in = den_q[i-1];
      assign p_in = pay_q[i-1];
    end

    assign sh   = {r_in, n_in[NW-1]};
    assign ge   = sh >= {1'b0, d_in};
    assign diff = sh - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[i] <= n_in << 1;
        quo_q[i] <= {q_in[NW-2:0], ge};
        rem_q[i] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        den_q[i] <= d_in;
        pay_q[i] <= p_in;
      end
    end
  end

  assign vld_o = vld_q[NW-1];
  assign quo_o = quo_q[NW-1];
  assign pay_o = pay_q[NW-1];

endmodule

### sv/lorentz_boost_general_velocity.sv
// One transfer per cycle sustained while the output is not stalled.
// Depth is set by the square root (30 stages) and the two dividers (63 and 32 stages).
// A stalled output freezes the whole pipeline; s_axis_tready_o follows that stall.
// Reset (rst_ni low, asynchronous) clears every valid bit; data registers keep junk.
// Results leave in input order, one per accepted item.
module lorentz_boost_general_velocity
  import lbgv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // energy_in, px_in, py_in, pz_in, beta_x, beta_y, beta_z
  input  logic [223:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // energy_out, px_out, py_out, pz_out
  output logic [127:0] m_axis_tdata_o,
  // status
  output logic [1:0]   m_axis_tuser_o
);

  localparam int F     = BETA_FRAC;
  localparam int RAD_W = 2 * F;
  localparam int G_W   = F + GAMMA_FRAC + 1;
  localparam int K_W   = 64;
  localparam int EP_W  = BP_W + 1;
  localparam int Y_W   = EP_W + K_W;
  localparam int EG_W  = MOM_W + K_W;
  localparam int BK_W  = BP_W + K_W + 1;
  localparam int U_W   = BK_W + 2;
  localparam int T_W   = U_W + BETA_W;
  localparam int S_W   = T_W + 1;
  localparam logic [63:0] ONE = 64'(1) << RAD_W;

  function automatic logic [MOM_W:0] sat_fn(input logic signed [S_W-1:0] v);
    logic [S_W-32:0] top;
    logic            fits;
    logic [MOM_W-1:0] r;
    top  = v[S_W-1:31];
    fits = (&top) | ~(|top);
    r    = fits ? v[MOM_W-1:0] : (v[S_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);
    return {~fits, r};
  endfunction

  logic adv;

  // stage 1
  logic signed [63:0] bb_d [3];
  logic signed [63:0] bpp_d [3];
  logic               v1_q;
  logic [63:0]        bb1_q [3];
  logic signed [63:0] bpp1_q [3];
  logic [127:0]       mom1_q;
  logic [95:0]        beta1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bb_d[i]  = $signed(s_axis_tdata_i[128+32*i +: 32]) *
                 $signed(s_axis_tdata_i[128+32*i +: 32]);
      bpp_d[i] = $signed(s_axis_tdata_i[128+32*i +: 32]) *
                 $signed(s_axis_tdata_i[32+32*i +: 32]);
    end
  end

  // stage 2
  logic               v2_q;
  logic [63:0]        bsq2_q;
  logic signed [BP_W-1:0] bp2_q;
  logic [127:0]       mom2_q;
  logic [95:0]        beta2_q;

  // stage 3
  logic               v3_q;
  logic [RAD_W-1:0]   d3_q;
  side_t              side3_q;
  kind_e              kind_d;
  logic [63:0]        d_full;

  always_comb begin
    if (bsq2_q == '0) begin
      kind_d = KIND_PASS;
    end else if (bsq2_q > ONE) begin
      kind_d = KIND_FTL;
    end else if (bsq2_q == ONE) begin
      kind_d = KIND_LIGHT;
    end else begin
      kind_d = KIND_BOOST;
    end
  end

  assign d_full = ONE - bsq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        bb1_q[i]  <= $unsigned(bb_d[i]);
        bpp1_q[i] <= bpp_d[i];
      end
      mom1_q  <= s_axis_tdata_i[127:0];
      beta1_q <= s_axis_tdata_i[223:128];
      bsq2_q  <= bb1_q[0] + bb1_q[1] + bb1_q[2];
      bp2_q   <= BP_W'(bpp1_q[0]) + BP_W'(bpp1_q[1]) + BP_W'(bpp1_q[2]);
      mom2_q  <= mom1_q;
      beta2_q <= beta1_q;
      d3_q         <= d_full[RAD_W-1:0];
      side3_q.mom  <= mom2_q;
      side3_q.beta <= beta2_q;
      side3_q.bp   <= bp2_q;
      side3_q.kind <= kind_d;
    end
  end

  // square root, one root bit per stage
  logic             sq_vld_q  [F];
  logic [RAD_W-1:0] sq_rad_q  [F];
  logic [F:0]       sq_rem_q  [F];
  logic [F-1:0]     sq_root_q [F];
  side_t            sq_side_q [F];

  for (genvar i = 0; i < F; i++) begin : g_sqrt
    logic             v_in;
    logic [RAD_W-1:0] rad_in;
    logic [F:0]       rem_in;
    logic [F-1:0]     root_in;
    side_t            side_in;
    logic [F+2:0]     sh;
    logic [F+2:0]     trial;
    logic             ge;
    logic [F+2:0]     diff;

    if (i == 0) begin : g_first
      assign v_in    = v3_q;
      assign rad_in  = d3_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side3_q;
    end else begin : g_next
      assign v_in    = sq_vld_q[i-1];
      assign rad_in  = sq_rad_q[i-1];
      assign rem_in  = sq_rem_q[i-1];
      assign root_in = sq_root_q[i-1];
      assign side_in = sq_side_q[i-1];
    end

    assign sh    = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = sh >= trial;
    assign diff  = sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[i] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rad_q[i]  <= rad_in << 2;
        sq_rem_q[i]  <= ge ? diff[F:0] : sh[F:0];
        sq_root_q[i] <= {root_in[F-2:0], ge};
        sq_side_q[i] <= side_in;
      end
    end
  end

  // gamma = 2^(F+32) / s
  logic             d1_vld;
  logic [G_W-1:0]   d1_g;
  logic [$bits(side_t)-1:0] d1_pay;

  lbgv_div #(
    .NW (G_W),
    .DW (F),
    .PW ($bits(side_t))
  ) u_div_gamma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (sq_vld_q[F-1]),
    .num_i  (G_W'(1) << (G_W - 1)),
    .rem_i  ('0),
    .den_i  (sq_root_q[F-1]),
    .pay_i  (sq_side_q[F-1]),
    .vld_o  (d1_vld),
    .quo_o  (d1_g),
    .pay_o  (d1_pay)
  );

  // 2^64 / (gamma + 1)
  logic             d2_vld;
  logic [GAMMA_FRAC-1:0] d2_q;
  logic [$bits(side_t)+G_W-1:0] d2_pay;
  side_t            d2_side;
  logic [G_W-1:0]   d2_g;

  lbgv_div #(
    .NW (GAMMA_FRAC),
    .DW (K_W),
    .PW ($bits(side_t) + G_W)
  ) u_div_k (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (d1_vld),
    .num_i  ('0),
    .rem_i  (K_W'(1) << GAMMA_FRAC),
    .den_i  (K_W'(d1_g) + (K_W'(1) << GAMMA_FRAC)),
    .pay_i  ({d1_pay, d1_g}),
    .vld_o  (d2_vld),
    .quo_o  (d2_q),
    .pay_o  (d2_pay)
  );

  assign {d2_side, d2_g} = d2_pay;

  // stage K: k factor and energy term
  logic               vk_q;
  side_t              sidek_q;
  logic [G_W-1:0]     gk_q;
  logic [K_W-1:0]     kk_q;
  logic signed [EP_W-1:0] epk_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sidek_q <= d2_side;
      gk_q    <= d2_g;
      kk_q    <= K_W'(d2_g) - (K_W'(1) << GAMMA_FRAC) + K_W'(d2_q);
      epk_q   <= (EP_W'($signed(d2_side.mom[0])) <<< F) + EP_W'(d2_side.bp);
    end
  end

  logic signed [Y_W-1:0]  y0_m;
  logic signed [EG_W-1:0] eg_m;
  logic signed [BK_W-1:0] bk_m;

  lbgv_mul #(.WA(EP_W), .WB(K_W), .WR(Y_W)) u_mul_e (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (epk_q),
    .b_i   ($signed(K_W'(gk_q))),
    .p_o   (y0_m)
  );

  lbgv_mul #(.WA(MOM_W), .WB(K_W), .WR(EG_W)) u_mul_eg (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   ($signed(sidek_q.mom[0])),
    .b_i   ($signed(K_W'(gk_q))),
    .p_o   (eg_m)
  );

  lbgv_mul #(.WA(BP_W), .WB(K_W+1), .WR(BK_W)) u_mul_bk (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (sidek_q.bp),
    .b_i   ($signed((K_W+1)'(kk_q))),
    .p_o   (bk_m)
  );

  logic  mq_vld_q  [2];
  side_t mq_side_q [2];

  // stage U
  logic               vu_q;
  side_t              sideu_q;
  logic signed [Y_W-1:0] y0u_q;
  logic signed [U_W-1:0] uu_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mq_side_q[0] <= sidek_q;
      mq_side_q[1] <= mq_side_q[0];
      sideu_q      <= mq_side_q[1];
      y0u_q        <= y0_m;
      uu_q         <= (U_W'(eg_m) <<< F) + U_W'(bk_m);
    end
  end

  logic signed [T_W-1:0] t_m [3];

  for (genvar i = 0; i < 3; i++) begin : g_mul_b
    lbgv_mul #(.WA(U_W), .WB(BETA_W), .WR(T_W)) u_mul_t (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (uu_q),
      .b_i   ($signed(sideu_q.beta[i])),
      .p_o   (t_m[i])
    );
  end

  logic                  mt_vld_q  [2];
  side_t                 mt_side_q [2];
  logic signed [Y_W-1:0] mt_y0_q   [2];

  // stage S
  logic                  vs_q;
  side_t                 sides_q;
  logic signed [Y_W-1:0] y0s_q;
  logic signed [S_W-1:0] sums_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mt_side_q[0] <= sideu_q;
      mt_side_q[1] <= mt_side_q[0];
      mt_y0_q[0]   <= y0u_q;
      mt_y0_q[1]   <= mt_y0_q[0];
      sides_q      <= mt_side_q[1];
      y0s_q        <= mt_y0_q[1];
      for (int i = 0; i < 3; i++) begin
        sums_q[i] <= (S_W'($signed(mt_side_q[1].mom[i+1])) <<< (2*F + GAMMA_FRAC)) +
                     S_W'(t_m[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q        <= 1'b0;
      mq_vld_q[0] <= 1'b0;
      mq_vld_q[1] <= 1'b0;
      vu_q        <= 1'b0;
      mt_vld_q[0] <= 1'b0;
      mt_vld_q[1] <= 1'b0;
      vs_q        <= 1'b0;
    end else if (adv) begin
      vk_q        <= d2_vld;
      mq_vld_q[0] <= vk_q;
      mq_vld_q[1] <= mq_vld_q[0];
      vu_q        <= mq_vld_q[1];
      mt_vld_q[0] <= vu_q;
      mt_vld_q[1] <= mt_vld_q[0];
      vs_q        <= mt_vld_q[1];
    end
  end

  // output stage: saturate and select
  logic [MOM_W:0]   sat_e;
  logic [MOM_W:0]   sat_p [3];
  logic [127:0]     res_d;
  status_e          status_d;

  always_comb begin
    sat_e = sat_fn(S_W'(y0s_q >>> (F + GAMMA_FRAC)));
    for (int i = 0; i < 3; i++) begin
      sat_p[i] = sat_fn(sums_q[i] >>> (2*F + GAMMA_FRAC));
    end
    case (sides_q.kind)
      KIND_PASS: begin
        res_d    = sides_q.mom;
        status_d = STATUS_OK;
      end
      KIND_FTL: begin
        res_d    = '0;
        status_d = STATUS_FTL;
      end
      KIND_LIGHT: begin
        res_d    = '0;
        status_d = STATUS_LIGHT;
      end
      default: begin
        res_d    = {sat_p[2][MOM_W-1:0], sat_p[1][MOM_W-1:0],
                    sat_p[0][MOM_W-1:0], sat_e[MOM_W-1:0]};
        status_d = (sat_e[MOM_W] | sat_p[0][MOM_W] | sat_p[1][MOM_W] | sat_p[2][MOM_W]) ?
                   STATUS_SAT : STATUS_OK;
      end
    endcase
  end

  logic         out_vld_q;
  logic [127:0] out_data_q;
  status_e      out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q   <= res_d;
      out_status_q <= status_d;
    end
  end

  assign adv             = ~out_vld_q | m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

`ifndef SYNTHESIS
  a_ftl_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == STATUS_FTL) |-> (m_axis_tdata_o == '0))
    else $error("faster than light result not zero");

  a_light_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == STATUS_LIGHT) |-> (m_axis_tdata_o == '0))
    else $error("light speed result not zero");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted during output stall");

  a_stall_holds_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (vs_q == $past(vs_q)))
    else $error("pipeline advanced during stall");
`endif

endmodule
